>>> hdl/a256x4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a256x4_pkg
// Shared types, constants and the AES S-box for the AEGIS-256X4 state core.
// ----------------------------------------------------------------------------
package a256x4_pkg;

	localparam int NumWords  = 48;
	localparam int NumBlocks = 6;
	localparam int NumLanes  = 24;

	typedef logic [63:0]  word_t;
	typedef logic [127:0] lane_t;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_UPDATE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Forward AES S-box.
	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] r;
		unique case (x)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

>>> hdl/a256x4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a256x4_lane
// One 128-bit lane: keyless AES round of the source lane XOR the own lane.
// ----------------------------------------------------------------------------
module a256x4_lane
	import a256x4_pkg::*;
(
	input  lane_t src,
	input  lane_t own,
	output lane_t result
);

	logic [7:0] sr [16];
	logic [7:0] mc [16];

	// SubBytes and ShiftRows; byte n of the lane sits at bits 8n+7:8n.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[r + 4 * c] = sbox(src[8 * (r + 4 * ((c + r) % 4)) +: 8]);
			end
		end
	end

	// MixColumns on each of the four columns.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			logic [7:0] t;
			t = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
			mc[4*c]   = sr[4*c]   ^ t ^ xtime(sr[4*c]   ^ sr[4*c+1]);
			mc[4*c+1] = sr[4*c+1] ^ t ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
			mc[4*c+2] = sr[4*c+2] ^ t ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
			mc[4*c+3] = sr[4*c+3] ^ t ^ xtime(sr[4*c+3] ^ sr[4*c]);
		end
	end

	// Pack and fold in the lane's own old value.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			result[8 * i +: 8] = mc[i] ^ own[8 * i +: 8];
		end
	end

endmodule

>>> hdl/aegis256x4_state_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aegis256x4_state_update_core
// AEGIS-256X4 state register with load, read and state update.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     op, word_index, msg_w0..msg_w7
// out      output     out_valid / out_stall   read_word
//
// For every request, 24 lane units compute the full update in
// parallel and the state register is written at the accepting edge.
// One result per request appears in the output register the next cycle.
// A new request is accepted while the output register is empty or being taken.
// Reset clears the whole state to zero and empties the output register.
// ----------------------------------------------------------------------------
module aegis256x4_state_update_core
	import a256x4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [5:0]  word_index,
	input  logic [63:0] msg_w0,
	input  logic [63:0] msg_w1,
	input  logic [63:0] msg_w2,
	input  logic [63:0] msg_w3,
	input  logic [63:0] msg_w4,
	input  logic [63:0] msg_w5,
	input  logic [63:0] msg_w6,
	input  logic [63:0] msg_w7,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] read_word
);

	word_t state_q [NumWords];
	lane_t new_lane [NumLanes];
	word_t msg [8];
	logic  accept;
	op_t   op_in;

	assign msg = '{msg_w0, msg_w1, msg_w2, msg_w3, msg_w4, msg_w5, msg_w6, msg_w7};
	assign op_in = op_t'(op);
	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;

	// Lane array: lane l of block b takes lane l of block b-1 (block 0 takes block 5).
	for (genvar b = 0; b < NumBlocks; b++) begin : g_blk
		for (genvar l = 0; l < 4; l++) begin : g_lane
			localparam int S = ((b + NumBlocks - 1) % NumBlocks) * 8 + 2 * l;
			localparam int D = b * 8 + 2 * l;
			lane_t own;
			if (b == 0) begin : g_msg
				assign own = {state_q[D+1] ^ msg[2*l+1], state_q[D] ^ msg[2*l]};
			end else begin : g_nomsg
				assign own = {state_q[D+1], state_q[D]};
			end
			a256x4_lane u_lane (
				.src    ({state_q[S+1], state_q[S]}),
				.own    (own),
				.result (new_lane[b*4+l])
			);
		end
	end

	// State register: merge the lane results or a single-word load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) state_q[i] <= '0;
		end else if (accept) begin
			if (op_in == OP_UPDATE) begin
				for (int i = 0; i < NumLanes; i++) begin
					state_q[2*i]   <= new_lane[i][63:0];
					state_q[2*i+1] <= new_lane[i][127:64];
				end
			end else if (op_in == OP_LOAD && word_index < 6'(NumWords)) begin
				state_q[word_index] <= msg_w0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (op_in == OP_READ && word_index < 6'(NumWords))
				read_word <= state_q[word_index];
			else
				read_word <= '0;
		end
	end

	// A stalled result never gets overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_word))
		else $error("result lost under stall");
	// Input is stalled only when a result is waiting.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("stall without pending result");
	// Non-read requests return zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op_in != OP_READ |=> read_word == '0)
		else $error("nonzero result for non-read");

endmodule

>>> dv/aegis256x4_state_update_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aegis256x4_state_update_core_test
// Checks the AEGIS-256X4 state core: word loads, word reads and full state
// updates are driven through the request channel, and every read_word that
// comes back is compared with a local model of the cipher state.
// ----------------------------------------------------------------------------
module aegis256x4_state_update_core_test;
	import a256x4_pkg::*;

	localparam int StallLimit = 20000;

	typedef struct {
		op_t        kind;
		logic [5:0] idx;
		word_t      msg [8];
		logic       known;
		word_t      want;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [5:0]  word_index;
	logic [63:0] msg_w0, msg_w1, msg_w2, msg_w3, msg_w4, msg_w5, msg_w6, msg_w7;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] read_word;

	word_t    cipher_words [NumWords];
	word_t    pending_words [$];
	int       error_count;
	int       idle_cycles;
	int       send_idle_pct;
	int       recv_stall_pct;
	logic     hold_off;
	request_t directed_rows [$];

	aegis256x4_state_update_core i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .word_index(word_index),
		.msg_w0(msg_w0), .msg_w1(msg_w1), .msg_w2(msg_w2), .msg_w3(msg_w3),
		.msg_w4(msg_w4), .msg_w5(msg_w5), .msg_w6(msg_w6), .msg_w7(msg_w7),
		.out_valid(out_valid), .out_stall(out_stall), .read_word(read_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Lookup table local to the testbench.
	function automatic logic [7:0] sub_byte(input logic [7:0] x);
		logic [7:0] s [256];
		s = '{
			8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
			8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
			8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
			8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
			8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
			8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
			8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
			8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
			8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
			8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
			8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
			8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
			8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
			8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
			8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
			8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return s[x];
	endfunction

	function automatic logic [7:0] double_byte(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ ({8{x[7]}} & 8'h1b);
	endfunction

	// One keyless AES round; lane bytes are little-endian, byte 0 in bits 7:0.
	function automatic lane_t aes_round(input lane_t lane);
		logic [7:0] shifted [16];
		logic [7:0] a [4];
		logic [7:0] t;
		lane_t      res;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				shifted[r + 4*c] = sub_byte(lane[8*(r + 4*((c + r) % 4)) +: 8]);
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++)
				a[r] = shifted[4*c + r];
			t = a[0] ^ a[1] ^ a[2] ^ a[3];
			for (int r = 0; r < 4; r++)
				res[8*(4*c + r) +: 8] = a[r] ^ t ^ double_byte(a[r] ^ a[(r + 1) % 4]);
		end
		return res;
	endfunction

	// Applies one request to the model state and returns the read word.
	function automatic word_t apply_request(input request_t req);
		word_t next [NumWords];
		lane_t lane;
		word_t res;
		int    s, d;
		res = '0;
		case (req.kind)
			OP_LOAD: begin
				if (req.idx < NumWords)
					cipher_words[req.idx] = req.msg[0];
			end
			OP_UPDATE: begin
				for (int b = 0; b < NumBlocks; b++)
					for (int l = 0; l < 4; l++) begin
						s = ((b + NumBlocks - 1) % NumBlocks) * 8 + 2*l;
						d = b*8 + 2*l;
						lane = aes_round({cipher_words[s+1], cipher_words[s]});
						lane ^= {cipher_words[d+1], cipher_words[d]};
						if (b == 0)
							lane ^= {req.msg[2*l+1], req.msg[2*l]};
						next[d] = lane[63:0];
						next[d+1] = lane[127:64];
					end
				cipher_words = next;
			end
			OP_READ: begin
				if (req.idx < NumWords)
					res = cipher_words[req.idx];
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic request_t random_request();
		request_t req;
		int       pick;
		pick = $urandom_range(0, 99);
		req.kind = pick < 35 ? OP_LOAD : pick < 65 ? OP_UPDATE : pick < 95 ? OP_READ : OP_NONE;
		req.idx = $urandom_range(0, 99) < 90 ? 6'($urandom_range(0, NumWords - 1))
			: 6'($urandom_range(0, 63));
		foreach (req.msg[k])
			req.msg[k] = rand_word();
		req.known = 1'b0;
		req.want = '0;
		return req;
	endfunction

	function automatic request_t make_row(input op_t kind, input logic [5:0] idx, input word_t w0,
			input logic known, input word_t want);
		request_t req;
		req.kind = kind;
		req.idx = idx;
		foreach (req.msg[k])
			req.msg[k] = '0;
		req.msg[0] = w0;
		req.known = known;
		req.want = want;
		return req;
	endfunction

	// Sends one request, waiting for acceptance, and records its expected word.
	task automatic send_request(input request_t req);
		word_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req.kind;
		word_index <= req.idx;
		{msg_w7, msg_w6, msg_w5, msg_w4, msg_w3, msg_w2, msg_w1, msg_w0} <=
			{req.msg[7], req.msg[6], req.msg[5], req.msg[4],
			 req.msg[3], req.msg[2], req.msg[1], req.msg[0]};
		do
			@(posedge clk);
		while (in_stall);
		want = apply_request(req);
		if (req.known && want !== req.want)
			report_mismatch("model row", want, req.want);
		pending_words.push_back(want);
	endtask

	// Receiver: random stalls plus an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Compares each accepted result with the oldest expected word.
	always @(posedge clk) begin : check_out
		word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected read_word", read_word, '0);
			end else begin
				want = pending_words.pop_front();
				if (read_word !== want)
					report_mismatch("read_word", read_word, want);
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		request_t req;
		int       settle;
		error_count = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_NONE;
		word_index = '0;
		{msg_w0, msg_w1, msg_w2, msg_w3, msg_w4, msg_w5, msg_w6, msg_w7} = '0;
		foreach (cipher_words[k])
			cipher_words[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset state, extremes, range edges, unused op, update before load.
		directed_rows.push_back(make_row(OP_READ, 6'd0, '0, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd47, '0, 1'b1, '0));
		directed_rows.push_back(make_row(OP_UPDATE, 6'd0, '0, 1'b0, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd0, '0, 1'b0, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd9, '0, 1'b0, '0));
		directed_rows.push_back(make_row(OP_LOAD, 6'd0, '1, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd0, '0, 1'b1, '1));
		directed_rows.push_back(make_row(OP_LOAD, 6'd47, 64'h0123456789abcdef, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd47, '0, 1'b1, 64'h0123456789abcdef));
		directed_rows.push_back(make_row(OP_LOAD, 6'd48, '1, 1'b1, '0));
		directed_rows.push_back(make_row(OP_LOAD, 6'd63, '1, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd48, '0, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd63, '0, 1'b1, '0));
		directed_rows.push_back(make_row(OP_NONE, 6'd0, '1, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd0, '0, 1'b1, '1));
		directed_rows.push_back(make_row(OP_UPDATE, 6'd63, '1, 1'b1, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd0, '0, 1'b0, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd8, '0, 1'b0, '0));
		directed_rows.push_back(make_row(OP_READ, 6'd40, '0, 1'b0, '0));
		foreach (directed_rows[k])
			send_request(directed_rows[k]);

		// Random part in idling phases, then a long receiver hold-off.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				3: begin send_idle_pct = 27; recv_stall_pct = 27; end
				default: begin send_idle_pct = 0; recv_stall_pct = 10; end
			endcase
			if (phase == 4)
				fork
					begin
						hold_off = 1'b1;
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			for (int n = 0; n < 140; n++) begin
				req = random_request();
				send_request(req);
			end
		end
		in_valid <= 1'b0;

		settle = 0;
		while (pending_words.size() != 0 && settle < StallLimit) begin
			@(posedge clk);
			settle++;
		end
		repeat (5) @(posedge clk);
		if (error_count == 0 && pending_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
